// ===== design/pidt_pkg.sv =====
// pidt_pkg: types and constants shared by the tustin pid controller modules
// no dependencies; used by pidt_csr, pidt_datapath and pid_tustin_controller
`timescale 1ns / 1ps
`default_nettype none

package pidt_pkg;

   localparam int GainW   = 24;
   localparam int LimitW  = 15;
   localparam int SampleW = 16;
   localparam int ErrorW  = SampleW + 1;
   localparam int OutW    = 48;
   localparam int FracW   = 16;
   localparam int DriveW  = 16;
   localparam int IndexW  = 2;

   localparam logic [GainW-1:0]  PropGainReset   = 24'd65536;
   localparam logic [GainW-1:0]  IntegCoeffReset = 24'd0;
   localparam logic [GainW-1:0]  DerivCoeffReset = 24'd0;
   localparam logic [LimitW-1:0] LimitReset      = 15'd32767;

   typedef enum logic [IndexW-1:0] {
      REG_PROP_GAIN    = 2'd0,
      REG_INTEG_COEFF  = 2'd1,
      REG_DERIV_COEFF  = 2'd2,
      REG_OUTPUT_LIMIT = 2'd3
   } pidt_reg_type;

   typedef struct packed {
      logic [GainW-1:0]  prop_gain;
      logic [GainW-1:0]  integ_coeff;
      logic [GainW-1:0]  deriv_coeff;
      logic [LimitW-1:0] output_limit;
   } pidt_cfg_type;

   typedef struct packed {
      logic signed [ErrorW-1:0] error_last;
      logic signed [ErrorW-1:0] error_before_last;
      logic signed [OutW-1:0]   output_last;
      logic signed [OutW-1:0]   output_before_last;
   } pidt_state_type;

   typedef struct packed {
      logic signed [ErrorW-1:0] error_now;
      logic signed [OutW-1:0]   output_next;
      logic [DriveW-1:0]        drive;
      logic                     clamped;
   } pidt_calc_type;

endpackage

`default_nettype wire

// ===== design/pidt_csr.sv =====
// pidt_csr: configuration registers of the tustin pid controller
// depends on pidt_pkg
`timescale 1ns / 1ps
`default_nettype none

module pidt_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wen,
   input  wire logic [pidt_pkg::IndexW-1:0]     csr_index,
   input  wire logic [pidt_pkg::GainW-1:0]      csr_wdata,
   output pidt_pkg::pidt_cfg_type               cfg
);

   pidt_pkg::pidt_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (pidt_pkg::pidt_reg_type'(csr_index))
            pidt_pkg::REG_PROP_GAIN:    cfg_in.prop_gain    = csr_wdata;
            pidt_pkg::REG_INTEG_COEFF:  cfg_in.integ_coeff  = csr_wdata;
            pidt_pkg::REG_DERIV_COEFF:  cfg_in.deriv_coeff  = csr_wdata;
            pidt_pkg::REG_OUTPUT_LIMIT:
               cfg_in.output_limit = csr_wdata[pidt_pkg::LimitW-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= pidt_pkg::PropGainReset;
         cfg_ff.integ_coeff  <= pidt_pkg::IntegCoeffReset;
         cfg_ff.deriv_coeff  <= pidt_pkg::DerivCoeffReset;
         cfg_ff.output_limit <= pidt_pkg::LimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/pidt_datapath.sv =====
// pidt_datapath: one sample of the incremental pid law with clamp and anti-windup
// combinational; depends on pidt_pkg
`timescale 1ns / 1ps
`default_nettype none

module pidt_datapath (
   input  wire logic signed [pidt_pkg::SampleW-1:0] measured,
   input  wire logic signed [pidt_pkg::SampleW-1:0] reference,
   input  wire pidt_pkg::pidt_cfg_type              cfg,
   input  wire pidt_pkg::pidt_state_type            state,
   output pidt_pkg::pidt_calc_type                  calc
);

   localparam int ErrorW = pidt_pkg::ErrorW;
   localparam int OutW   = pidt_pkg::OutW;
   localparam int FracW  = pidt_pkg::FracW;
   localparam int DriveW = pidt_pkg::DriveW;
   localparam int LimitW = pidt_pkg::LimitW;
   localparam int ProdW  = pidt_pkg::GainW + 1 + ErrorW + 2;
   localparam int SumW   = OutW + 2;

   logic signed [ErrorW-1:0]          e0;
   logic signed [ErrorW:0]            diff_p;
   logic signed [ErrorW+1:0]          diff_i;
   logic signed [ErrorW+1:0]          diff_d;
   logic signed [pidt_pkg::GainW:0]   gain_p, gain_i, gain_d;
   logic signed [ProdW-1:0]           p_term, i_term, d_term;
   logic signed [SumW-1:0]            y_full;
   logic signed [OutW-1:0]            y_sat;
   logic signed [OutW:0]              y_wind;
   logic signed [OutW-1:0]            y_wind_sat;
   logic signed [OutW-1:0]            y_round;
   logic signed [LimitW+FracW+1:0]    lim_pos, lim_neg;
   logic                              over_hi, over_lo;
   logic [DriveW-1:0]                 lim_drive;

   assign e0     = ErrorW'(reference) - ErrorW'(measured);
   assign diff_p = (ErrorW+1)'(e0) - (ErrorW+1)'(state.error_before_last);
   assign diff_i = (ErrorW+2)'(e0) + ((ErrorW+2)'(state.error_last) <<< 1)
                   + (ErrorW+2)'(state.error_before_last);
   assign diff_d = (ErrorW+2)'(e0) - ((ErrorW+2)'(state.error_last) <<< 1)
                   + (ErrorW+2)'(state.error_before_last);

   assign gain_p = $signed({1'b0, cfg.prop_gain});
   assign gain_i = $signed({1'b0, cfg.integ_coeff});
   assign gain_d = $signed({1'b0, cfg.deriv_coeff});

   assign p_term = gain_p * diff_p;
   assign i_term = gain_i * diff_i;
   assign d_term = gain_d * diff_d;

   assign y_full = SumW'(state.output_before_last) + SumW'(p_term)
                   + SumW'(i_term) + SumW'(d_term);

   // saturate to the 48-bit state range
   always_comb begin
      if (y_full[SumW-1:OutW-1] == '0 || y_full[SumW-1:OutW-1] == '1) begin
         y_sat = y_full[OutW-1:0];
      end else if (y_full[SumW-1]) begin
         y_sat = {1'b1, {(OutW-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(OutW-1){1'b1}}};
      end
   end

   // anti-windup: integral contribution removed from the stored output
   assign y_wind = (OutW+1)'(y_sat) - (OutW+1)'(i_term);

   always_comb begin
      if (y_wind[OutW] == y_wind[OutW-1]) begin
         y_wind_sat = y_wind[OutW-1:0];
      end else if (y_wind[OutW]) begin
         y_wind_sat = {1'b1, {(OutW-1){1'b0}}};
      end else begin
         y_wind_sat = {1'b0, {(OutW-1){1'b1}}};
      end
   end

   assign lim_pos   = $signed({2'b00, cfg.output_limit, {FracW{1'b0}}});
   assign lim_neg   = -lim_pos;
   assign over_hi   = y_sat > OutW'(lim_pos);
   assign over_lo   = y_sat < OutW'(lim_neg);
   assign lim_drive = {1'b0, cfg.output_limit};

   // truncation toward zero of the fraction
   assign y_round = y_sat + (y_sat[OutW-1] ? OutW'({FracW{1'b1}}) : OutW'(0));

   always_comb begin
      calc.error_now = e0;
      if (over_hi) begin
         calc.output_next = y_wind_sat;
         calc.drive       = lim_drive;
         calc.clamped     = 1'b1;
      end else if (over_lo) begin
         calc.output_next = y_wind_sat;
         calc.drive       = -lim_drive;
         calc.clamped     = 1'b1;
      end else begin
         calc.output_next = y_sat;
         calc.drive       = y_round[FracW+DriveW-1:FracW];
         calc.clamped     = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== design/pid_tustin_controller.sv =====
// pid_tustin_controller: discrete pid controller, tustin incremental form,
// with output clamp and anti-windup; one sample per cycle while the receiver does not stall.
//
// req channel: one transaction per sample, tdata = {reference, measured}.
// rsp channel: one transaction per sample, tdata = drive, tuser = clamped.
// csr port: write enable, index (0 prop_gain, 1 integ_coeff, 2 deriv_coeff,
// 3 output_limit) and data; the user must write it only while no sample is in
// flight, which the block itself does not enforce.
// the input register is loaded at the accepting edge, the result register,
// which raises rsp_tvalid, when the sample advances, together with the error
// and output history. throughput: one sample per cycle while the receiver
// does not stall, as each sample feeds the history registers to the next.
// when the receiver stalls, the result register holds and the input register
// still takes one more sample; req_tready drops only when both are full.
// reset clears both stages, the error and output history and loads the
// register defaults (gain 1.0, coefficients 0, limit 32767).
// depends on pidt_pkg, pidt_csr and pidt_datapath
`timescale 1ns / 1ps
`default_nettype none

module pid_tustin_controller (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [31:0]                 req_tdata,  // reference, measured
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   output      logic [15:0]                 rsp_tdata,  // drive
   output      logic                        rsp_tuser,  // clamped
   input  wire logic                        csr_wen,
   input  wire logic [pidt_pkg::IndexW-1:0] csr_index,
   input  wire logic [pidt_pkg::GainW-1:0]  csr_wdata
);

   localparam int SampleW = pidt_pkg::SampleW;

   pidt_pkg::pidt_cfg_type   cfg;
   pidt_pkg::pidt_calc_type  calc;
   pidt_pkg::pidt_state_type state_ff, state_in;

   logic                      in_valid_ff, in_valid_in;
   logic [2*SampleW-1:0]      in_data_ff, in_data_in;
   logic                      out_valid_ff, out_valid_in;
   logic [15:0]               out_drive_ff, out_drive_in;
   logic                      out_clamped_ff, out_clamped_in;
   logic                      advance;
   logic                      req_take;

   pidt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidt_datapath u_datapath (
      .measured  ($signed(in_data_ff[SampleW-1:0])),
      .reference ($signed(in_data_ff[2*SampleW-1:SampleW])),
      .cfg       (cfg),
      .state     (state_ff),
      .calc      (calc)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_data_in     = in_data_ff;
      out_valid_in   = out_valid_ff;
      out_drive_in   = out_drive_ff;
      out_clamped_in = out_clamped_ff;
      state_in       = state_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in                 = 1'b0;
         out_valid_in                = 1'b1;
         out_drive_in                = calc.drive;
         out_clamped_in              = calc.clamped;
         state_in.error_before_last  = state_ff.error_last;
         state_in.error_last         = calc.error_now;
         state_in.output_before_last = state_ff.output_last;
         state_in.output_last        = calc.output_next;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff     <= in_data_in;
      out_drive_ff   <= out_drive_in;
      out_clamped_ff <= out_clamped_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_drive_ff;
   assign rsp_tuser  = out_clamped_ff;

endmodule

`default_nettype wire

// ===== design/pidt_checker.sv =====
// pidt_checker: port-level checks on the tustin pid controller
// bound to pid_tustin_controller; uses no package
`timescale 1ns / 1ps
`default_nettype none

module pidt_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [15:0]                 rsp_tdata,
   input wire logic                        rsp_tuser
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // an empty result register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty result register");

   // accepted sample moves to the output at the next edge when the receiver is ready
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted sample did not reach rsp");

   // drive is always within plus or minus 32767
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 16'h8000)
      else $error("drive out of symmetric range");

endmodule

bind pid_tustin_controller pidt_checker u_pidt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
